>>> sv/tcw_pkg.sv
package tcw_pkg;

   typedef enum logic [2:0] {
      MODE_PUT_CHAR = 3'd0,
      MODE_PUT_HEX  = 3'd1,
      MODE_SET_COL  = 3'd2,
      MODE_SET_ROW  = 3'd3,
      MODE_CLEAR    = 3'd4,
      MODE_READ     = 3'd5
   } mode_type;

   localparam logic [0:0] CSR_CELL_COLOR = 1'b0;
   localparam logic [0:0] CSR_TAB_WIDTH  = 1'b1;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_RETURN  = 8'h0D;
   localparam logic [7:0] CHAR_BACK    = 8'h08;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   localparam logic [7:0] RESET_COLOR = 8'd3;
   localparam logic [6:0] RESET_TAB   = 7'd4;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) r = 8'h30 + {4'd0, nib};
      else r = 8'h37 + {4'd0, nib};
      return r;
   endfunction

endpackage

>>> sv/tcw_if.sv
interface tcw_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [7:0] data_byte;
   logic [6:0] column_value;
   logic [4:0] row_value;
   modport source (output valid, mode, data_byte, column_value, row_value, input ready);
   modport sink (input valid, mode, data_byte, column_value, row_value, output ready);
endinterface

interface tcw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_char;
   logic [7:0] read_color;
   logic [6:0] cursor_column;
   logic [4:0] cursor_row;
   modport source (output valid, read_char, read_color, cursor_column, cursor_row,
                   input ready);
   modport sink (input valid, read_char, read_color, cursor_column, cursor_row,
                 output ready);
endinterface

>>> sv/text_console_writer.sv
// channel | dir | handshake   | payload
// req     | in  | valid/ready | mode, data_byte, column_value, row_value
// rsp     | out | valid/ready | read_char, read_color, cursor_column, cursor_row
// csr     | in  | write only  | cell_color (0), tab_width (1)
// one item at a time; the screen lives in one memory with a registered read port
// newline writes spaces to the end of the row; tab finds col mod t by repeated
// subtraction, then writes spaces; a pending wrap moves to the next row first; at
// the bottom row a scroll copies each cell up one row and blanks the bottom row
// clear blanks every cell and homes the cursor; after reset a clearing pass runs
// rsp is a register; req is taken again the cycle after the response transfer
module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if.sink    req,
   tcw_rsp_if.source  rsp,
   input  logic       csr_write,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_data
);
   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW = $clog2(CELLS);
   localparam int CW = $clog2(COLUMNS + 1);
   localparam int RW = $clog2(ROWS);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_DECODE = 10'b0000000010,
      ST_WRITE  = 10'b0000000100,
      ST_SCRRD  = 10'b0000001000,
      ST_SCRWR  = 10'b0000010000,
      ST_BLANK  = 10'b0000100000,
      ST_CLEAR  = 10'b0001000000,
      ST_RDWAIT = 10'b0010000000,
      ST_RDDONE = 10'b0100000000,
      ST_RESP   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [15:0] mem [CELLS];
   logic [15:0] rd_ff;
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [15:0]   wdata;

   logic [7:0] color_ff;
   logic [6:0] tab_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [2:0] mode_ff, mode_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] ch_ff, ch_in;       // character for next raw write
   logic [7:0] cnt_ff, cnt_in;     // spaces still to write
   logic       hex2_ff, hex2_in;   // second hex digit pending
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [15:0] rsp_rd_ff, rsp_rd_in;
   logic       rsp_v_ff;
   logic [6:0] rcol_ff;
   logic [4:0] rrow_ff;

   // row times columns, columns small constant
   logic [AW-1:0] cur_addr;
   logic [AW-1:0] rd_addr;
   assign cur_addr = AW'(row_ff * COLUMNS) + AW'(col_ff);
   assign rd_addr  = AW'(rrow_ff * COLUMNS) + AW'(rcol_ff);

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= tcw_pkg::RESET_COLOR;
         tab_ff   <= tcw_pkg::RESET_TAB;
      end else if (csr_write) begin
         if (csr_index == tcw_pkg::CSR_CELL_COLOR) color_ff <= csr_data;
         else tab_ff <= csr_data[6:0];
      end
   end

   // tab space count: t minus (col mod t), the remainder found by repeated subtraction
   logic [6:0] teff;
   logic [7:0] tab_rem;
   logic [7:0] tab_cnt;
   assign teff = (tab_ff == 7'd0) ? 7'd1 : tab_ff;
   // remainder kept in trem_ff, reduced by t once per decode cycle
   logic [7:0] trem_ff, trem_in;
   assign tab_rem = trem_ff;
   assign tab_cnt = 8'(teff) - tab_rem;

   // operands of the current command
   logic [6:0] colv_ff;
   logic req_col_big, rowv_big;
   assign req_col_big = colv_ff > 7'(COLUMNS);
   assign rowv_big = 8'(rrow_ff) >= 8'(ROWS);

   // the reset clearing pass ends in ST_RESP without an item
   logic clr_resp_skip_ff;

   assign req.ready = (state_ff == ST_IDLE) && !rsp_v_ff;

   always_comb begin
      state_in = state_ff;
      col_in = col_ff; row_in = row_ff;
      mode_in = mode_ff; data_in = data_ff; ch_in = ch_ff; cnt_in = cnt_ff;
      hex2_in = hex2_ff; ptr_in = ptr_ff; rsp_rd_in = rsp_rd_ff; trem_in = trem_ff;
      we = 1'b0; waddr = cur_addr; wdata = {color_ff, ch_ff}; raddr = ptr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               mode_in = req.mode; data_in = req.data_byte;
               rsp_rd_in = 16'd0; hex2_in = 1'b0; cnt_in = 8'd0;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_RESP;
            case (mode_ff)
               tcw_pkg::MODE_PUT_CHAR: begin
                  if (data_ff == tcw_pkg::CHAR_NEWLINE) begin
                     cnt_in = (col_ff >= CW'(COLUMNS)) ? 8'(COLUMNS)
                                                       : 8'(COLUMNS) - 8'(col_ff);
                     ch_in = tcw_pkg::CHAR_SPACE; state_in = ST_BLANK;
                  end else if (data_ff == tcw_pkg::CHAR_TAB) begin
                     if (trem_ff < 8'(teff)) begin
                        cnt_in = tab_cnt; ch_in = tcw_pkg::CHAR_SPACE;
                        state_in = ST_BLANK;
                     end else begin
                        trem_in = trem_ff - 8'(teff); state_in = ST_DECODE;
                     end
                  end else if (data_ff == tcw_pkg::CHAR_RETURN) begin
                     state_in = ST_RESP;
                  end else begin
                     if (data_ff == tcw_pkg::CHAR_BACK) begin
                        if (col_ff == '0) begin
                           col_in = CW'(COLUMNS - 1);
                           if (row_ff != '0) row_in = row_ff - 1'b1;
                        end else col_in = col_ff - 1'b1;
                     end
                     ch_in = data_ff; state_in = ST_WRITE;
                  end
               end
               tcw_pkg::MODE_PUT_HEX: begin
                  ch_in = tcw_pkg::hex_digit(data_ff[7:4]); hex2_in = 1'b1;
                  state_in = ST_WRITE;
               end
               tcw_pkg::MODE_SET_COL:
                  col_in = (req_col_big) ? CW'(COLUMNS) : CW'(colv_ff);
               tcw_pkg::MODE_SET_ROW:
                  row_in = (rowv_big) ? RW'(ROWS - 1) : RW'(rrow_ff);
               tcw_pkg::MODE_CLEAR: begin
                  ptr_in = '0; state_in = ST_CLEAR;
               end
               tcw_pkg::MODE_READ: begin
                  if (rcol_ff < 7'(COLUMNS) && 8'(rrow_ff) < 8'(ROWS)) begin
                     raddr = rd_addr; state_in = ST_RDWAIT;
                  end
               end
               default: ;
            endcase
         end
         ST_WRITE: begin
            // raw write with wrap and scroll
            if (col_ff >= CW'(COLUMNS) && row_ff == RW'(ROWS - 1)) begin
               ptr_in = '0; state_in = ST_SCRRD;
            end else if (col_ff >= CW'(COLUMNS)) begin
               col_in = '0; row_in = row_ff + 1'b1;
            end else begin
               we = 1'b1;
               col_in = col_ff + 1'b1;
               if (hex2_ff) begin
                  hex2_in = 1'b0; ch_in = tcw_pkg::hex_digit(data_ff[3:0]);
               end else if (cnt_ff > 8'd1) cnt_in = cnt_ff - 8'd1;
               else begin
                  cnt_in = 8'd0; state_in = ST_RESP;
               end
            end
         end
         ST_BLANK: begin
            ch_in = tcw_pkg::CHAR_SPACE; state_in = ST_WRITE;
         end
         ST_SCRRD: begin
            // read source cell one row below
            raddr = ptr_ff + AW'(COLUMNS);
            state_in = ST_SCRWR;
            if (ptr_ff >= AW'(CELLS - COLUMNS)) begin
               we = 1'b1; waddr = ptr_ff; wdata = {color_ff, tcw_pkg::CHAR_SPACE};
               if (ptr_ff == AW'(CELLS - 1)) begin
                  col_in = '0; row_in = RW'(ROWS - 1); state_in = ST_WRITE;
               end else begin
                  ptr_in = ptr_ff + 1'b1; state_in = ST_SCRRD;
               end
            end
         end
         ST_SCRWR: begin
            we = 1'b1; waddr = ptr_ff; wdata = rd_ff;
            ptr_in = ptr_ff + 1'b1; state_in = ST_SCRRD;
         end
         ST_CLEAR: begin
            we = 1'b1; waddr = ptr_ff; wdata = {color_ff, tcw_pkg::CHAR_SPACE};
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == AW'(CELLS - 1)) begin
               col_in = '0; row_in = '0; state_in = ST_RESP;
            end
         end
         ST_RDWAIT: begin
            raddr = rd_addr; state_in = ST_RDDONE;
         end
         ST_RDDONE: begin
            rsp_rd_in = rd_ff; state_in = ST_RESP;
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) clr_resp_skip_ff <= 1'b1;
      else if (state_ff == ST_RESP) clr_resp_skip_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         col_ff <= '0; row_ff <= '0; ptr_ff <= '0;
         rsp_v_ff <= 1'b0; hex2_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         state_ff <= (state_ff == ST_RESP) ? ST_IDLE : state_in;
         col_ff <= col_in; row_ff <= row_in; ptr_ff <= ptr_in;
         hex2_ff <= hex2_in; cnt_ff <= cnt_in;
         if (state_ff == ST_RESP && !clr_resp_skip_ff) rsp_v_ff <= 1'b1;
         else if (rsp.ready) rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in; data_ff <= data_in; ch_ff <= ch_in;
      rsp_rd_ff <= rsp_rd_in;
      if (state_ff == ST_IDLE && req.valid && req.ready) begin
         colv_ff <= req.column_value; rcol_ff <= req.column_value;
         rrow_ff <= req.row_value;
         trem_ff <= 8'(col_ff);
      end else trem_ff <= trem_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RESP) begin
         rsp.read_char     <= rsp_rd_ff[7:0];
         rsp.read_color    <= rsp_rd_ff[15:8];
         rsp.cursor_column <= 7'(col_ff);
         rsp.cursor_row    <= 5'(row_ff);
      end
   end
   assign rsp.valid = rsp_v_ff;

endmodule

>>> tb/tcw_checker.sv
`timescale 1ns / 100ps

module tcw_checker (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if         req,
   tcw_rsp_if         rsp,
   input  logic       csr_write,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_data,
   output int         fail_count,
   output int         pending_count
);

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   typedef struct packed {
      logic [7:0] read_char;
      logic [7:0] read_color;
      logic [6:0] cursor_column;
      logic [4:0] cursor_row;
   } console_view_type;

   logic [15:0]      screen [CELLS];
   int               col_pos;
   int               row_pos;
   logic [7:0]       colour;
   logic [6:0]       tab_step;
   console_view_type view_queue [$];

   assign pending_count = view_queue.size();

   function automatic logic [15:0] blank_cell();
      return {colour, tcw_pkg::CHAR_SPACE};
   endfunction

   function automatic logic [7:0] nibble_char(input logic [3:0] nib);
      return (nib < 4'd10) ? 8'h30 + nib : 8'h41 + (nib - 4'd10);
   endfunction

   task automatic blank_screen();
      for (int i = 0; i < CELLS; i++) screen[i] = blank_cell();
   endtask

   task automatic emit_cell(input logic [7:0] ch);
      if (col_pos >= COLUMNS) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= ROWS) begin
         for (int i = 0; i < COLUMNS * (ROWS - 1); i++) screen[i] = screen[i + COLUMNS];
         for (int i = COLUMNS * (ROWS - 1); i < CELLS; i++) screen[i] = blank_cell();
         col_pos = 0;
         row_pos = ROWS - 1;
      end
      screen[row_pos * COLUMNS + col_pos] = {colour, ch};
      col_pos++;
   endtask

   task automatic emit_spaces(input int count);
      for (int i = 0; i < count; i++) emit_cell(tcw_pkg::CHAR_SPACE);
   endtask

   task automatic type_char(input logic [7:0] ch);
      int t;
      if (ch == tcw_pkg::CHAR_NEWLINE) begin
         emit_spaces(col_pos >= COLUMNS ? COLUMNS : COLUMNS - col_pos);
      end else if (ch == tcw_pkg::CHAR_TAB) begin
         t = (tab_step == 0) ? 1 : int'(tab_step);
         emit_spaces(((col_pos + t) / t) * t - col_pos);
      end else if (ch != tcw_pkg::CHAR_RETURN) begin
         if (ch == tcw_pkg::CHAR_BACK) begin
            if (col_pos == 0) begin
               col_pos = COLUMNS - 1;
               if (row_pos > 0) row_pos--;
            end else begin
               col_pos--;
            end
         end
         emit_cell(ch);
      end
   endtask

   task automatic apply_command(input logic [2:0] mode, input logic [7:0] data,
                                input logic [6:0] colv, input logic [4:0] rowv);
      console_view_type v;
      logic [15:0]      c;
      v = '0;
      case (mode)
         tcw_pkg::MODE_PUT_CHAR: type_char(data);
         tcw_pkg::MODE_PUT_HEX: begin
            emit_cell(nibble_char(data[7:4]));
            emit_cell(nibble_char(data[3:0]));
         end
         tcw_pkg::MODE_SET_COL: col_pos = (colv > COLUMNS) ? COLUMNS : int'(colv);
         tcw_pkg::MODE_SET_ROW: row_pos = (rowv >= ROWS) ? ROWS - 1 : int'(rowv);
         tcw_pkg::MODE_CLEAR: begin
            blank_screen();
            col_pos = 0;
            row_pos = 0;
         end
         tcw_pkg::MODE_READ: begin
            if (colv < COLUMNS && rowv < ROWS) begin
               c = screen[rowv * COLUMNS + colv];
               v.read_char  = c[7:0];
               v.read_color = c[15:8];
            end
         end
         default: ;
      endcase
      v.cursor_column = col_pos[6:0];
      v.cursor_row    = row_pos[4:0];
      view_queue.push_back(v);
   endtask

   always @(posedge clock) begin
      console_view_type want;
      console_view_type got;
      if (reset) begin
         colour   = tcw_pkg::RESET_COLOR;
         tab_step = tcw_pkg::RESET_TAB;
         col_pos  = 0;
         row_pos  = 0;
         blank_screen();
         view_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == tcw_pkg::CSR_CELL_COLOR) colour = csr_data;
            else tab_step = csr_data[6:0];
         end
         // response first: it belongs to an earlier transfer
         if (rsp.valid && rsp.ready) begin
            got = {rsp.read_char, rsp.read_color, rsp.cursor_column, rsp.cursor_row};
            if (view_queue.size() == 0) begin
               $display("%0t: unexpected response got %h", $time, got);
               fail_count++;
            end else begin
               want = view_queue.pop_front();
               if (want !== got) begin
                  $display("%0t: mismatch exp char %h col %h cx %0d cy %0d",
                           $time, want.read_char, want.read_color,
                           want.cursor_column, want.cursor_row);
                  $display("%0t:          got char %h col %h cx %0d cy %0d",
                           $time, got.read_char, got.read_color,
                           got.cursor_column, got.cursor_row);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready)
            apply_command(req.mode, req.data_byte, req.column_value, req.row_value);
      end
   end

endmodule

>>> tb/text_console_writer_tb.sv
`timescale 1ns / 100ps

module text_console_writer_tb;

   localparam int CYCLE_LIMIT = 20000000;

   logic       clock;
   logic       reset;
   logic       csr_write;
   logic [0:0] csr_index;
   logic [7:0] csr_data;
   int         fail_count;
   int         pending_count;
   int         cycle_count;
   int         send_idle_pct;
   int         recv_idle_pct;

   tcw_req_if req ();
   tcw_rsp_if rsp ();

   text_console_writer u_top (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   tcw_checker u_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_command(input logic [2:0] mode, input logic [7:0] data,
                               input logic [6:0] colv, input logic [4:0] rowv);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid        <= 1'b1;
      req.mode         <= mode;
      req.data_byte    <= data;
      req.column_value <= colv;
      req.row_value    <= rowv;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [0:0] idx, input logic [7:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_command();
      int         pick;
      logic [7:0] ch;
      pick = $urandom_range(99);
      ch   = 8'($urandom_range(255));
      if (pick < 45) begin
         if ($urandom_range(3) == 0) ch = 8'(8'h41 + $urandom_range(25));
         send_command(tcw_pkg::MODE_PUT_CHAR, ch, 7'($urandom), 5'($urandom));
      end else if (pick < 55) begin
         case ($urandom_range(3))
            0: ch = tcw_pkg::CHAR_NEWLINE;
            1: ch = tcw_pkg::CHAR_TAB;
            2: ch = tcw_pkg::CHAR_RETURN;
            default: ch = tcw_pkg::CHAR_BACK;
         endcase
         send_command(tcw_pkg::MODE_PUT_CHAR, ch, 7'($urandom), 5'($urandom));
      end else if (pick < 63) begin
         send_command(tcw_pkg::MODE_PUT_HEX, ch, 7'($urandom), 5'($urandom));
      end else if (pick < 70) begin
         send_command(tcw_pkg::MODE_SET_COL, ch, 7'($urandom_range(127)), 5'($urandom));
      end else if (pick < 77) begin
         send_command(tcw_pkg::MODE_SET_ROW, ch, 7'($urandom), 5'($urandom_range(31)));
      end else if (pick < 78) begin
         send_command(tcw_pkg::MODE_CLEAR, ch, 7'($urandom), 5'($urandom));
      end else if (pick < 98) begin
         send_command(tcw_pkg::MODE_READ, ch, 7'($urandom_range(127)),
                      5'($urandom_range(31)));
      end else begin
         send_command(3'(3'd6 + $urandom_range(1)), ch, 7'($urandom), 5'($urandom));
      end
   endtask

   initial begin
      send_idle_pct    = 17;
      recv_idle_pct    = 60;
      reset            = 1'b1;
      csr_write        = 1'b0;
      csr_index        = tcw_pkg::CSR_CELL_COLOR;
      csr_data         = '0;
      req.valid        = 1'b0;
      req.mode         = tcw_pkg::MODE_PUT_CHAR;
      req.data_byte    = '0;
      req.column_value = '0;
      req.row_value    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset screen, extremes and every control code
      send_command(tcw_pkg::MODE_READ, 8'h00, 7'd0, 5'd0);
      send_command(tcw_pkg::MODE_READ, 8'h00, 7'd79, 5'd24);
      send_command(tcw_pkg::MODE_READ, 8'h00, 7'd80, 5'd0);
      send_command(tcw_pkg::MODE_READ, 8'h00, 7'd127, 5'd31);
      send_command(tcw_pkg::MODE_PUT_CHAR, 8'hFF, 7'd0, 5'd0);
      send_command(tcw_pkg::MODE_PUT_CHAR, 8'h00, 7'd0, 5'd0);
      send_command(tcw_pkg::MODE_PUT_HEX, 8'hA5, 7'd0, 5'd0);
      send_command(tcw_pkg::MODE_PUT_CHAR, tcw_pkg::CHAR_TAB, 7'd0, 5'd0);
      send_command(tcw_pkg::MODE_PUT_CHAR, tcw_pkg::CHAR_RETURN, 7'd0, 5'd0);
      send_command(tcw_pkg::MODE_PUT_CHAR, tcw_pkg::CHAR_BACK, 7'd0, 5'd0);
      send_command(tcw_pkg::MODE_PUT_CHAR, tcw_pkg::CHAR_NEWLINE, 7'd0, 5'd0);
      send_command(tcw_pkg::MODE_PUT_CHAR, tcw_pkg::CHAR_BACK, 7'd0, 5'd0);
      send_command(tcw_pkg::MODE_SET_COL, 8'h00, 7'd0, 5'd0);
      send_command(tcw_pkg::MODE_SET_ROW, 8'h00, 7'd0, 5'd0);
      send_command(tcw_pkg::MODE_PUT_CHAR, tcw_pkg::CHAR_BACK, 7'd0, 5'd0);
      send_command(tcw_pkg::MODE_SET_COL, 8'h00, 7'd127, 5'd0);
      send_command(tcw_pkg::MODE_PUT_CHAR, tcw_pkg::CHAR_NEWLINE, 7'd0, 5'd0);
      send_command(tcw_pkg::MODE_SET_ROW, 8'h00, 7'd0, 5'd31);
      send_command(tcw_pkg::MODE_SET_COL, 8'h00, 7'd80, 5'd0);
      send_command(tcw_pkg::MODE_PUT_HEX, 8'h5A, 7'd0, 5'd0);
      send_command(tcw_pkg::MODE_READ, 8'h00, 7'd0, 5'd23);
      send_command(3'd6, 8'h00, 7'd0, 5'd0);
      send_command(3'd7, 8'hFF, 7'd127, 5'd31);
      send_command(tcw_pkg::MODE_CLEAR, 8'h00, 7'd0, 5'd0);
      drain_responses();

      write_register(tcw_pkg::CSR_CELL_COLOR, 8'hFF);
      write_register(tcw_pkg::CSR_TAB_WIDTH, 8'd80);
      for (int i = 0; i < 300; i++) random_command();
      drain_responses();

      send_idle_pct = 60;
      recv_idle_pct = 17;
      write_register(tcw_pkg::CSR_CELL_COLOR, 8'h00);
      write_register(tcw_pkg::CSR_TAB_WIDTH, 8'd1);
      for (int i = 0; i < 300; i++) random_command();
      drain_responses();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_register(tcw_pkg::CSR_CELL_COLOR, 8'($urandom_range(255)));
      write_register(tcw_pkg::CSR_TAB_WIDTH, 8'($urandom_range(1, 80)));
      for (int i = 0; i < 150; i++) random_command();
      drain_responses();
      write_register(tcw_pkg::CSR_TAB_WIDTH, 8'h00);
      write_register(tcw_pkg::CSR_CELL_COLOR, 8'h5C);
      for (int i = 0; i < 150; i++) random_command();
      drain_responses();

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
